### rtl/sna_pkg.sv
// ----------------------------------------------------------------------------
// sna_pkg
// Shared types, constants and helpers for the slab node allocator.
// ----------------------------------------------------------------------------
package sna_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_SLABS = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SLAB_W    = $clog2(MAX_SLABS);
    localparam int REF_W     = NODE_W + SLAB_W;
    localparam int CNT_W     = NODE_W + 1;
    localparam int LINK_W    = SLAB_W + 1;
    localparam int MEM_DEPTH = MAX_SLABS * MAX_NODES;

    // Reserved codes for an empty stack head and an empty list link.
    localparam logic [CNT_W-1:0]  NO_NODE = CNT_W'(MAX_NODES);
    localparam logic [LINK_W-1:0] NO_SLAB = LINK_W'(MAX_SLABS);

    // Configuration register indexes.
    localparam logic [1:0] CFG_NODES = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_LIMIT    = 2'd1,
        STAT_BAD_REF  = 2'd2,
        STAT_NOT_USED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_EXEC,
        S_MEM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             func;
        logic [REF_W-1:0] node_ref;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [REF_W-1:0] granted_ref;
        logic [4:0]       live_slabs;
    } rsp_t;

    // Node count as used: zero counts as one, large values are clamped.
    function automatic logic [CNT_W-1:0] eff_nodes(input logic [6:0] v);
        logic [CNT_W-1:0] r;
        begin
            if (v == 7'd0) r = CNT_W'(1);
            else if (v > 7'(MAX_NODES)) r = CNT_W'(MAX_NODES);
            else r = CNT_W'(v);
            return r;
        end
    endfunction

    // Slab limit as used: values above the slab count are clamped.
    function automatic logic [4:0] eff_limit(input logic [4:0] v);
        logic [4:0] r;
        begin
            if (v > 5'(MAX_SLABS)) r = 5'(MAX_SLABS);
            else r = v;
            return r;
        end
    endfunction

endpackage

### rtl/slab_node_allocator.sv
// ----------------------------------------------------------------------------
// slab_node_allocator
// Allocates and frees fixed-size nodes grouped in slabs, one request a time.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the in channel (valid/ready): func 0 allocates
// a node, func 1 frees node_ref. Each request yields one result beat on the
// out channel with a status, the granted node reference and the live slab
// count. Per-slab bookkeeping sits in flops; node links and in-use flags sit
// in one 1024-entry synchronous RAM with registered read data.
// A request passes from acceptance through S_EXEC to S_DONE when no RAM read
// is needed (new slab, untouched node, or a request rejected in S_EXEC), and
// through S_EXEC, S_MEM and S_DONE when the RAM is read (popping a freed
// node, or a free with a valid reference). The next request is accepted in
// the cycle after the result is loaded into the output register.
// After reset and after every write to CFG_NODES or CFG_LIMIT the block runs
// a clearing pass over the node RAM with in_ready low; these configuration
// writes are taken at any time and restart the pass.
// If the receiver stalls, the result holds in the output register while the
// next request is accepted and worked on; that one waits for the register.
// ----------------------------------------------------------------------------
module slab_node_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  sna_pkg::req_t       in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sna_pkg::rsp_t       out_data
);

    localparam int NS = sna_pkg::MAX_SLABS;
    localparam int CW = sna_pkg::CNT_W;
    localparam int LW = sna_pkg::LINK_W;
    localparam int SW = sna_pkg::SLAB_W;
    localparam int NW = sna_pkg::NODE_W;
    localparam int RW = sna_pkg::REF_W;
    localparam int MW = CW + 1;

    // Configuration and control registers.
    logic [6:0]        nodes_reg;
    logic [4:0]        limit_reg;
    sna_pkg::state_t   state_reg, state_next;
    logic [RW-1:0]     clr_cnt_reg;
    sna_pkg::req_t     req_reg;
    sna_pkg::rsp_t     res_reg, res_next;
    logic              out_valid_reg;
    sna_pkg::rsp_t     out_data_reg;

    // Per-slab tables.
    logic              live_reg  [NS];
    logic [CW-1:0]     used_reg  [NS];
    logic [CW-1:0]     untch_reg [NS];
    logic [CW-1:0]     head_reg  [NS];
    logic [LW-1:0]     lnext_reg [NS];
    logic [LW-1:0]     lprev_reg [NS];
    logic [LW-1:0]     first_reg;
    logic [4:0]        total_reg;

    logic              live_next  [NS];
    logic [CW-1:0]     used_next  [NS];
    logic [CW-1:0]     untch_next [NS];
    logic [CW-1:0]     head_next  [NS];
    logic [LW-1:0]     lnext_next [NS];
    logic [LW-1:0]     lprev_next [NS];
    logic [LW-1:0]     first_next;
    logic [4:0]        total_next;

    // Node RAM: bit CW is the in-use flag, the low bits the free link.
    logic [MW-1:0]     node_mem [sna_pkg::MEM_DEPTH];
    logic [MW-1:0]     mem_rdata;
    logic              mem_re, mem_we;
    logic [RW-1:0]     mem_raddr, mem_waddr;
    logic [MW-1:0]     mem_wdata;

    logic              cfg_hit;
    logic [6:0]        nodes_new;
    logic [4:0]        limit_new;
    logic [CW-1:0]     nc;
    logic [4:0]        lim;
    logic              need_read;

    assign nc  = sna_pkg::eff_nodes(nodes_reg);
    assign lim = sna_pkg::eff_limit(limit_reg);

    assign cfg_hit   = cfg_we && (cfg_index == sna_pkg::CFG_NODES ||
                                  cfg_index == sna_pkg::CFG_LIMIT);
    assign nodes_new = (cfg_we && cfg_index == sna_pkg::CFG_NODES) ? cfg_data : nodes_reg;
    assign limit_new = (cfg_we && cfg_index == sna_pkg::CFG_LIMIT) ? cfg_data[4:0]
                                                                   : limit_reg;

    assign in_ready  = (state_reg == sna_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= 7'(sna_pkg::MAX_NODES);
            limit_reg <= 5'(sna_pkg::MAX_SLABS);
        end
        else
        begin
            nodes_reg <= nodes_new;
            limit_reg <= limit_new;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sna_pkg::S_IDLE:  if (in_valid) state_next = sna_pkg::S_EXEC;
            sna_pkg::S_CLEAR: if (clr_cnt_reg == '1) state_next = sna_pkg::S_IDLE;
            sna_pkg::S_EXEC:  state_next = need_read ? sna_pkg::S_MEM : sna_pkg::S_DONE;
            sna_pkg::S_MEM:   state_next = sna_pkg::S_DONE;
            sna_pkg::S_DONE:  if (!out_valid_reg || out_ready) state_next = sna_pkg::S_IDLE;
            default:          state_next = sna_pkg::S_IDLE;
        endcase
        if (cfg_hit) state_next = sna_pkg::S_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sna_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit) clr_cnt_reg <= '0;
            else if (state_reg == sna_pkg::S_CLEAR) clr_cnt_reg <= clr_cnt_reg + RW'(1);
        end
    end

    // Request datapath: slab table updates, list edits and RAM accesses.
    always_comb
    begin
        logic [SW-1:0] s;
        logic [NW-1:0] nd;
        logic [SW-1:0] fslot;
        logic          found;
        logic          do_push, do_unlink;
        logic [SW-1:0] push_s, unl_s;
        logic [LW-1:0] p, n;
        logic [CW-1:0] used_new;

        for (int i = 0; i < NS; i++)
        begin
            live_next[i]  = live_reg[i];
            used_next[i]  = used_reg[i];
            untch_next[i] = untch_reg[i];
            head_next[i]  = head_reg[i];
            lnext_next[i] = lnext_reg[i];
            lprev_next[i] = lprev_reg[i];
        end
        first_next = first_reg;
        total_next = total_reg;
        res_next   = res_reg;
        need_read  = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = req_reg.node_ref;
        mem_we     = 1'b0;
        mem_waddr  = clr_cnt_reg;
        mem_wdata  = '0;
        do_push    = 1'b0;
        do_unlink  = 1'b0;
        push_s     = '0;
        unl_s      = '0;
        p          = '0;
        n          = '0;
        used_new   = '0;
        nd         = '0;
        s          = req_reg.func ? req_reg.node_ref[RW-1:NW] : first_reg[SW-1:0];

        // Lowest slot that is not live.
        found = 1'b0;
        fslot = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                found = 1'b1;
                fslot = SW'(i);
            end
        end

        case (state_reg)
            sna_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            sna_pkg::S_EXEC:
            begin
                res_next.status      = sna_pkg::STAT_OK;
                res_next.granted_ref = '0;
                if (!req_reg.func)
                begin
                    if (first_reg[LW-1])
                    begin
                        // Not-full list is empty: open a new slab.
                        if (total_reg >= lim || !found)
                        begin
                            res_next.status = sna_pkg::STAT_LIMIT;
                        end
                        else
                        begin
                            nd = NW'(nc - CW'(1));
                            live_next[fslot]  = 1'b1;
                            used_next[fslot]  = CW'(1);
                            untch_next[fslot] = nc - CW'(1);
                            head_next[fslot]  = sna_pkg::NO_NODE;
                            total_next        = total_reg + 5'd1;
                            do_push           = 1'b1;
                            push_s            = fslot;
                            do_unlink         = (nc == CW'(1));
                            unl_s             = fslot;
                            mem_we            = 1'b1;
                            mem_waddr         = {fslot, nd};
                            mem_wdata         = {1'b1, CW'(0)};
                            res_next.granted_ref = {fslot, nd};
                        end
                    end
                    else if (!head_reg[s][CW-1])
                    begin
                        // Pop a freed node: its link comes from the RAM.
                        need_read = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = {s, head_reg[s][NW-1:0]};
                    end
                    else if (untch_reg[s] != '0)
                    begin
                        nd = NW'(untch_reg[s] - CW'(1));
                        untch_next[s] = untch_reg[s] - CW'(1);
                        used_new      = used_reg[s] + CW'(1);
                        used_next[s]  = used_new;
                        do_unlink     = (used_new >= nc);
                        unl_s         = s;
                        mem_we        = 1'b1;
                        mem_waddr     = {s, nd};
                        mem_wdata     = {1'b1, CW'(0)};
                        res_next.granted_ref = {s, nd};
                    end
                    else
                    begin
                        res_next.status = sna_pkg::STAT_LIMIT;
                    end
                end
                else
                begin
                    if (!live_reg[s] || {1'b0, req_reg.node_ref[NW-1:0]} >= nc)
                    begin
                        res_next.status = sna_pkg::STAT_BAD_REF;
                    end
                    else
                    begin
                        need_read = 1'b1;
                        mem_re    = 1'b1;
                    end
                end
            end
            sna_pkg::S_MEM:
            begin
                if (!req_reg.func)
                begin
                    nd = head_reg[s][NW-1:0];
                    head_next[s] = mem_rdata[CW-1:0];
                    used_new     = used_reg[s] + CW'(1);
                    used_next[s] = used_new;
                    do_unlink    = (used_new >= nc);
                    unl_s        = s;
                    mem_we       = 1'b1;
                    mem_waddr    = {s, nd};
                    mem_wdata    = {1'b1, mem_rdata[CW-1:0]};
                    res_next.granted_ref = {s, nd};
                end
                else if (!mem_rdata[CW])
                begin
                    res_next.status = sna_pkg::STAT_NOT_USED;
                end
                else
                begin
                    nd = req_reg.node_ref[NW-1:0];
                    // A full slab that gets a node back rejoins the list head.
                    do_push      = (used_reg[s] >= nc);
                    push_s       = s;
                    mem_we       = 1'b1;
                    mem_waddr    = req_reg.node_ref;
                    mem_wdata    = {1'b0, head_reg[s]};
                    head_next[s] = {1'b0, nd};
                    used_new     = (used_reg[s] != '0) ? used_reg[s] - CW'(1) : used_reg[s];
                    used_next[s] = used_new;
                    // An emptied slab other than slab 0 is released.
                    if (used_new == '0 && s != '0)
                    begin
                        do_unlink    = 1'b1;
                        unl_s        = s;
                        live_next[s] = 1'b0;
                        if (total_reg != '0) total_next = total_reg - 5'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // List edits: push first, then unlink, on the updated copies.
        if (do_push)
        begin
            lnext_next[push_s] = first_next;
            lprev_next[push_s] = sna_pkg::NO_SLAB;
            if (!first_next[LW-1]) lprev_next[first_next[SW-1:0]] = {1'b0, push_s};
            first_next = {1'b0, push_s};
        end
        if (do_unlink)
        begin
            p = lprev_next[unl_s];
            n = lnext_next[unl_s];
            if (first_next == {1'b0, unl_s}) first_next = n;
            else if (!p[LW-1]) lnext_next[p[SW-1:0]] = n;
            if (!n[LW-1]) lprev_next[n[SW-1:0]] = p;
        end

        res_next.live_slabs = total_next;
    end

    // Slab tables: reset and configuration both re-create the pool.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                live_reg[i]  <= (i == 0);
                used_reg[i]  <= '0;
                untch_reg[i] <= (i == 0) ? CW'(sna_pkg::MAX_NODES) : '0;
                head_reg[i]  <= sna_pkg::NO_NODE;
                lnext_reg[i] <= sna_pkg::NO_SLAB;
                lprev_reg[i] <= sna_pkg::NO_SLAB;
            end
            first_reg <= '0;
            total_reg <= 5'd1;
        end
        else if (cfg_hit)
        begin
            for (int i = 0; i < NS; i++)
            begin
                live_reg[i]  <= (i == 0);
                used_reg[i]  <= '0;
                untch_reg[i] <= (i == 0) ? sna_pkg::eff_nodes(nodes_new) : '0;
                head_reg[i]  <= sna_pkg::NO_NODE;
                lnext_reg[i] <= sna_pkg::NO_SLAB;
                lprev_reg[i] <= sna_pkg::NO_SLAB;
            end
            first_reg <= '0;
            total_reg <= 5'd1;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                live_reg[i]  <= live_next[i];
                used_reg[i]  <= used_next[i];
                untch_reg[i] <= untch_next[i];
                head_reg[i]  <= head_next[i];
                lnext_reg[i] <= lnext_next[i];
                lprev_reg[i] <= lprev_next[i];
            end
            first_reg <= first_next;
            total_reg <= total_next;
        end
    end

    // Node RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we) node_mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata <= node_mem[mem_raddr];
    end

    // Request capture and working result.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) req_reg <= in_data;
        if (state_reg == sna_pkg::S_EXEC || state_reg == sna_pkg::S_MEM) res_reg <= res_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == sna_pkg::S_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sna_pkg::S_DONE && (!out_valid_reg || out_ready))
            out_data_reg <= res_reg;
    end

    // A result always reports at least slab 0 live.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.live_slabs != 5'd0)
        else $error("live slab count of zero on a result");

    // A granted reference is zero unless the status is ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sna_pkg::STAT_OK |-> out_data.granted_ref == '0)
        else $error("granted reference set on a failed request");

    // A RAM read is consumed in the following cycle unless a configuration write intervenes.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re && !cfg_hit |=> state_reg == sna_pkg::S_MEM)
        else $error("node RAM read without a consuming cycle");

    // The live slab count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 5'(sna_pkg::MAX_SLABS))
        else $error("live slab count out of range");

endmodule
